FILE: rtl/core/rbn_pkg.sv
// Package for the rectangle bisection navigator: geometry widths, history depth,
// command and event codes, and the transaction payload types.
// Depends on nothing; rbn_channels and the core use it.
package rbn_pkg;

   localparam int COORD_BITS    = 15;
   localparam int HISTORY_DEPTH = 32;
   localparam int DEPTH_BITS    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int RECT_BITS     = 4 * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;

   localparam depth_type MAX_LEVEL = depth_type'(HISTORY_DEPTH - 1);

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } rect_type;

   // Command codes.
   localparam logic [2:0] CMD_START  = 3'd0;
   localparam logic [2:0] CMD_SELECT = 3'd1;
   localparam logic [2:0] CMD_BACK   = 3'd2;
   localparam logic [2:0] CMD_ACCEPT = 3'd3;
   localparam logic [2:0] CMD_CANCEL = 3'd4;
   localparam logic [2:0] CMD_CLICK  = 3'd5;

   // Event codes.
   localparam logic [2:0] EV_MOVED   = 3'd0;
   localparam logic [2:0] EV_IGNORED = 3'd1;
   localparam logic [2:0] EV_LEAVE   = 3'd2;
   localparam logic [2:0] EV_ACCEPT  = 3'd3;
   localparam logic [2:0] EV_CANCEL  = 3'd4;
   localparam logic [2:0] EV_CLICK   = 3'd5;

   localparam logic [1:0] BUTTON_NONE = 2'd0;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  sub_index;
      logic [1:0]  button;
      logic [14:0] start_x;
      logic [14:0] start_y;
      logic [14:0] start_w;
      logic [14:0] start_h;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [14:0] area_x;
      logic [14:0] area_y;
      logic [14:0] area_w;
      logic [14:0] area_h;
      logic [1:0]  click_button;
      logic [4:0]  level;
   } rsp_type;

endpackage

FILE: rtl/core/rbn_channels.sv
// Valid/ready channel interfaces for the command and result transactions.
// Depends on rbn_pkg for the payload types.
interface rbn_req_if;
   logic              valid;
   logic              ready;
   rbn_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rbn_rsp_if;
   logic              valid;
   logic              ready;
   rbn_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rbn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the area history stack.
module rbn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

FILE: rtl/core/rect_bisect_navigator_core.sv
// Top level of the rectangle bisection navigator: command stage, sub-area logic,
// history stack RAM and result register.
// Depends on rbn_pkg, rbn_channels (rbn_req_if, rbn_rsp_if) and rbn_ram.
//
// Usage. Each command transaction on req_chan (start, select, back, accept, cancel,
// click) produces exactly one result transaction on rsp_chan, in order. A start
// loads a root area at level 0; a select splits the current area into a 4x2 grid
// when it is wide (5w > 9h), else a 2x2 grid, or halves a one-pixel strip, and
// pushes the chosen piece; back pops one level or reports a leave at the root.
// Results carry the current area, its center pointer and level, all zero before a start.
//
// Timing. A command is registered when accepted and its result is registered when
// it leaves the command stage; one transaction is taken every cycle unless the
// receiver stalls. The only stored history is a RAM that reads the parent level
// ahead, so a pop has its area ready without a stall.
//
// Reset clears the command stage, the result register, the level and the loaded
// flag; no clearing pass over the stack RAM is needed. When the receiver stalls,
// the result holds and one more command can wait in the command stage; after that
// req_chan.ready drops until the result is taken.
module rect_bisect_navigator_core (
   input  logic           clock,
   input  logic           reset,
   rbn_req_if.sink        req_chan,
   rbn_rsp_if.source      rsp_chan
);

   // Command stage and result register handshake.
   logic             s1_valid_ff, s1_valid_in;
   rbn_pkg::req_type s1_data_ff, s1_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rbn_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             s1_adv;
   logic             req_acc;

   // Navigator state: the current area mirrors the stack entry at the current level.
   rbn_pkg::rect_type  cur_ff, cur_in;
   rbn_pkg::depth_type depth_ff, depth_in;
   logic               loaded_ff, loaded_in;

   // Stack RAM ports.
   logic                          ram_we;
   rbn_pkg::depth_type            ram_raddr;
   rbn_pkg::rect_type             ram_wdata;
   logic [rbn_pkg::RECT_BITS-1:0] ram_rdata;
   rbn_pkg::rect_type             parent;

   // Sub-area of the current area for the requested index.
   rbn_pkg::rect_type nr;
   logic              sub_ok;

   rbn_pkg::rect_type root;
   logic [2:0]        ev;
   logic [1:0]        click;
   logic              res_zero;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_chan.data;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sub-area selection. The grid branch works on fixed shifts and masks: columns
   // are four or two, rows always two, and remainder pixels widen the leading ones.
   always_comb begin
      logic [rbn_pkg::COORD_BITS+3:0] w5;
      logic [rbn_pkg::COORD_BITS+3:0] h9;
      logic                           wide;
      logic [1:0]                     col;
      logic                           row;
      rbn_pkg::coord_type             sw;
      rbn_pkg::coord_type             sh;
      logic [1:0]                     wo;
      logic                           ho;
      logic [rbn_pkg::COORD_BITS+1:0] col_off;
      logic [1:0]                     col_min;
      logic [rbn_pkg::COORD_BITS+1:0] x_sum;
      logic [rbn_pkg::COORD_BITS+1:0] y_sum;
      logic [2:0]                     idx;
      logic                           w_thin;
      logic                           h_thin;

      idx    = s1_data_ff.sub_index;
      w_thin = (cur_ff.w <= rbn_pkg::coord_type'(1));
      h_thin = (cur_ff.h <= rbn_pkg::coord_type'(1));
      w5 = ({4'b0, cur_ff.w} << 2) + {4'b0, cur_ff.w};
      h9 = ({4'b0, cur_ff.h} << 3) + {4'b0, cur_ff.h};
      wide = (w5 > h9);
      if (wide) begin
         col = idx[1:0];
         row = idx[2];
         sw  = cur_ff.w >> 2;
         wo  = cur_ff.w[1:0];
      end else begin
         col = {1'b0, idx[0]};
         row = idx[1];
         sw  = cur_ff.w >> 1;
         wo  = {1'b0, cur_ff.w[0]};
      end
      sh = cur_ff.h >> 1;
      ho = cur_ff.h[0];
      unique case (col)
         2'd0:    col_off = '0;
         2'd1:    col_off = {2'b0, sw};
         2'd2:    col_off = {1'b0, sw, 1'b0};
         default: col_off = {2'b0, sw} + {1'b0, sw, 1'b0};
      endcase
      col_min = (col < wo) ? col : wo;
      x_sum = {2'b0, cur_ff.x} + col_off + {{rbn_pkg::COORD_BITS{1'b0}}, col_min};
      y_sum = {2'b0, cur_ff.y} + (row ? {2'b0, sh} : '0)
            + {{(rbn_pkg::COORD_BITS+1){1'b0}}, row & ho};

      nr     = cur_ff;
      sub_ok = 1'b0;
      if (w_thin && h_thin) begin
         sub_ok = 1'b0;
      end else if (w_thin) begin
         sub_ok = (idx <= 3'd1);
         nr.h   = sh;
         nr.y   = cur_ff.y + (idx[0] ? sh : '0);
      end else if (h_thin) begin
         sub_ok = (idx <= 3'd1);
         nr.w   = cur_ff.w >> 1;
         nr.x   = cur_ff.x + (idx[0] ? (cur_ff.w >> 1) : '0);
      end else begin
         sub_ok = wide || !idx[2];
         nr.x   = x_sum[rbn_pkg::COORD_BITS-1:0];
         nr.y   = y_sum[rbn_pkg::COORD_BITS-1:0];
         nr.w   = sw + rbn_pkg::coord_type'(col < wo);
         nr.h   = sh + rbn_pkg::coord_type'(!row && ho);
      end
   end

   assign root.x = rbn_pkg::coord_type'(s1_data_ff.start_x);
   assign root.y = rbn_pkg::coord_type'(s1_data_ff.start_y);
   assign root.w = rbn_pkg::coord_type'(s1_data_ff.start_w);
   assign root.h = rbn_pkg::coord_type'(s1_data_ff.start_h);
   assign parent = rbn_pkg::rect_type'(ram_rdata);

   // Command execution. A start writes the root at level 0 and a select writes the
   // new piece one level up; the write address is always the new level, depth_in.
   always_comb begin
      cur_in    = cur_ff;
      depth_in  = depth_ff;
      loaded_in = loaded_ff;
      ram_we    = 1'b0;
      ram_wdata = nr;
      ev        = rbn_pkg::EV_IGNORED;
      click     = rbn_pkg::BUTTON_NONE;
      res_zero  = 1'b0;
      if (s1_adv) begin
         if (s1_data_ff.command == rbn_pkg::CMD_START) begin
            cur_in    = root;
            depth_in  = '0;
            loaded_in = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = root;
            ev        = rbn_pkg::EV_MOVED;
         end else if (!loaded_ff) begin
            res_zero = 1'b1;
         end else begin
            unique case (s1_data_ff.command)
               rbn_pkg::CMD_SELECT: begin
                  if (depth_ff != rbn_pkg::MAX_LEVEL && sub_ok) begin
                     depth_in = depth_ff + rbn_pkg::depth_type'(1);
                     cur_in   = nr;
                     ram_we   = 1'b1;
                     ev       = rbn_pkg::EV_MOVED;
                  end
               end
               rbn_pkg::CMD_BACK: begin
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - rbn_pkg::depth_type'(1);
                     cur_in   = parent;
                     ev       = rbn_pkg::EV_MOVED;
                  end else begin
                     ev = rbn_pkg::EV_LEAVE;
                  end
               end
               rbn_pkg::CMD_ACCEPT: ev = rbn_pkg::EV_ACCEPT;
               rbn_pkg::CMD_CANCEL: ev = rbn_pkg::EV_CANCEL;
               rbn_pkg::CMD_CLICK: begin
                  if (s1_data_ff.button != rbn_pkg::BUTTON_NONE) begin
                     ev    = rbn_pkg::EV_CLICK;
                     click = s1_data_ff.button;
                  end
               end
               default: ev = rbn_pkg::EV_IGNORED;
            endcase
         end
      end
   end

   // The parent of the next level is fetched every cycle, so it is ready for a pop.
   assign ram_raddr = depth_in - rbn_pkg::depth_type'(1);

   rbn_ram #(
      .WIDTH (rbn_pkg::RECT_BITS),
      .DEPTH (rbn_pkg::HISTORY_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (depth_in),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s1_adv) begin
         if (res_zero) begin
            rsp_data_in           = '0;
            rsp_data_in.event_res = rbn_pkg::EV_IGNORED;
         end else begin
            rsp_data_in.event_res    = ev;
            rsp_data_in.center_x     = 16'((rbn_pkg::COORD_BITS+1)'(cur_in.x)
                                     + (rbn_pkg::COORD_BITS+1)'(cur_in.w >> 1));
            rsp_data_in.center_y     = 16'((rbn_pkg::COORD_BITS+1)'(cur_in.y)
                                     + (rbn_pkg::COORD_BITS+1)'(cur_in.h >> 1));
            rsp_data_in.area_x       = 15'(cur_in.x);
            rsp_data_in.area_y       = 15'(cur_in.y);
            rsp_data_in.area_w       = 15'(cur_in.w);
            rsp_data_in.area_h       = 15'(cur_in.h);
            rsp_data_in.click_button = click;
            rsp_data_in.level        = 5'(depth_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         loaded_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         loaded_ff    <= loaded_in;
      end
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
      cur_ff      <= cur_in;
   end

   // Without a loaded area the stack stays at the root level.
   a_unloaded_root: assert property (@(posedge clock) disable iff (reset)
      !loaded_ff |-> depth_ff == '0)
      else $error("level moved with no area loaded");

   // A pop of a non-root level lowers the level by exactly one.
   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && loaded_ff && s1_data_ff.command == rbn_pkg::CMD_BACK && depth_ff != '0)
      |=> depth_ff == $past(depth_ff) - rbn_pkg::depth_type'(1))
      else $error("back did not pop one level");

   // Stack writes only happen on a start at level 0 or a push one level up.
   a_write_level: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (depth_in == '0 || depth_in == depth_ff + rbn_pkg::depth_type'(1)))
      else $error("stack write at an unexpected level");

   // A button code is reported only with a click event.
   a_click_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.click_button != rbn_pkg::BUTTON_NONE)
      |-> rsp_data_ff.event_res == rbn_pkg::EV_CLICK)
      else $error("click button without click event");

endmodule
